/* rtl/aff_pkg.sv */
// Shared widths, types, status codes and helpers for the affine inverse block.
package aff_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  localparam int W     = WORD_BITS;
  localparam int PW    = 2 * WORD_BITS;
  localparam int DW_O  = 2 * WORD_BITS + FRAC_BITS;
  localparam int DW_W  = WORD_BITS + 2 * FRAC_BITS;
  localparam int DW    = (DW_O > DW_W) ? DW_O : DW_W;
  localparam int HIW   = DW - WORD_BITS;
  localparam int CW    = (HIW > PW) ? HIW : PW;
  localparam int NLANE = 6;
  localparam int NCOEF = 6;

  localparam int TDATA_W = ((NCOEF * WORD_BITS + 7) / 8) * 8;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  typedef struct packed {
    logic         neg;
    logic [W-1:0] mag;
  } wsm_t;

  typedef struct packed {
    logic          neg;
    logic [PW-1:0] mag;
  } psm_t;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [PW-1:0] rem;
    logic [W-1:0]  low;
    logic [W-1:0]  q;
  } lane_t;

  typedef struct packed {
    logic          sing;
    logic [PW-1:0] den;
  } ctl_t;

  function automatic wsm_t to_sm(input logic [W-1:0] x);
    wsm_t r;
    r.neg = x[W-1];
    r.mag = x[W-1] ? (~x + 1'b1) : x;
    return r;
  endfunction

  // x - y in sign-magnitude
  function automatic psm_t sm_sub(input psm_t x, input psm_t y);
    psm_t r;
    logic yneg;
    yneg = ~y.neg;
    if (x.neg == yneg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = yneg;
      r.mag = y.mag - x.mag;
    end
    return r;
  endfunction

endpackage

/* rtl/affine_transform_inverter.sv */
// Affine 2D model inverter: top level with multiply, subtract and pipelined divide.
// Takes the six Q16.16 coefficients of a forward affine model in one transfer and returns
// the six coefficients of the inverse model plus a status code on m_tuser (0 ok,
// 1 singular with all coefficients zero, 2 some coefficient saturated). One model is
// accepted per clock while the skid is empty; the stages are input, multiply, subtract,
// dividend setup, one restoring-divide step per quotient bit and output, the divider
// being pipelined a bit per stage. A skid register at the output holds one result that
// arrives while the output is stalled, so s_tready comes from a register; once the skid
// is full the whole pipeline and the input stall until the output drains.
module affine_transform_inverter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // coef_a, coef_b, coef_c, coef_d, coef_e, coef_f
  input  logic [aff_pkg::TDATA_W-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // inv_a, inv_b, inv_c, inv_d, inv_e, inv_f
  output logic [aff_pkg::TDATA_W-1:0]  m_tdata,
  // status
  output logic [1:0]                   m_tuser
);
  import aff_pkg::*;

  // stage 1: sign-magnitude inputs
  logic v1;
  wsm_t c1 [NCOEF];
  // stage 2: products bf, ce, cd, af, ae, bd
  logic v2;
  wsm_t c2 [NCOEF];
  psm_t p2 [6];
  // stage 3: det and offset numerators
  logic v3;
  wsm_t c3 [NCOEF];
  psm_t det3, na3, nd3;
  // divider stages
  logic  dv [W+1];
  lane_t dl [W+1][NLANE];
  ctl_t  dc [W+1];

  lane_t d0 [NLANE];
  lane_t dn [W][NLANE];

  // output register and skid
  logic                vo, vs;
  logic [TDATA_W-1:0]  od, sd;
  logic [1:0]          ou, su;
  logic [TDATA_W-1:0]  res_data;
  logic [1:0]          res_stat;

  logic en;
  assign en       = ~vs;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NCOEF; i++) begin
        c1[i] <= to_sm(s_tdata[i*W +: W]);
        c2[i] <= c1[i];
        c3[i] <= c2[i];
      end
      p2[0] <= '{c1[1].neg ^ c1[5].neg, c1[1].mag * c1[5].mag};
      p2[1] <= '{c1[2].neg ^ c1[4].neg, c1[2].mag * c1[4].mag};
      p2[2] <= '{c1[2].neg ^ c1[3].neg, c1[2].mag * c1[3].mag};
      p2[3] <= '{c1[0].neg ^ c1[5].neg, c1[0].mag * c1[5].mag};
      p2[4] <= '{c1[0].neg ^ c1[4].neg, c1[0].mag * c1[4].mag};
      p2[5] <= '{c1[1].neg ^ c1[3].neg, c1[1].mag * c1[3].mag};
      det3 <= sm_sub(p2[0], p2[1]);
      na3  <= sm_sub(p2[2], p2[3]);
      nd3  <= sm_sub(p2[4], p2[5]);
      dc[0] <= '{det3.mag == '0, det3.mag};
      for (int l = 0; l < NLANE; l++) dl[0][l] <= d0[l];
      for (int k = 0; k < W; k++) begin
        dc[k+1] <= dc[k];
        for (int l = 0; l < NLANE; l++) dl[k+1][l] <= dn[k][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int k = 0; k <= W; k++) dv[k] <= 1'b0;
    end else if (en) begin
      v1    <= s_tvalid;
      v2    <= v1;
      v3    <= v2;
      dv[0] <= v3;
      for (int k = 0; k < W; k++) dv[k+1] <= dv[k];
    end
  end

  // dividend setup and overflow check (quotient needs more than W bits)
  always_comb begin
    psm_t          num [NLANE];
    logic [DW-1:0] dvd;
    logic [CW-1:0] hi, den;
    num[0] = na3;
    num[1] = '{c3[5].neg, {(PW-W)'(0), c3[5].mag}};
    num[2] = '{~c3[2].neg, {(PW-W)'(0), c3[2].mag}};
    num[3] = nd3;
    num[4] = '{~c3[4].neg, {(PW-W)'(0), c3[4].mag}};
    num[5] = '{c3[1].neg, {(PW-W)'(0), c3[1].mag}};
    den = CW'(det3.mag);
    for (int l = 0; l < NLANE; l++) begin
      if (l == 0 || l == 3) dvd = DW'(num[l].mag) << FRAC_BITS;
      else                  dvd = DW'(num[l].mag) << (2 * FRAC_BITS);
      hi = CW'(dvd[DW-1:W]);
      d0[l].neg = num[l].neg ^ det3.neg;
      d0[l].ovf = hi >= den;
      d0[l].rem = hi[PW-1:0];
      d0[l].low = dvd[W-1:0];
      d0[l].q   = '0;
    end
  end

  // one restoring-divide step per stage
  always_comb begin
    logic [PW:0] t;
    logic        ge;
    for (int k = 0; k < W; k++) begin
      for (int l = 0; l < NLANE; l++) begin
        t  = {dl[k][l].rem, dl[k][l].low[W-1]};
        ge = t >= {1'b0, dc[k].den};
        dn[k][l].neg = dl[k][l].neg;
        dn[k][l].ovf = dl[k][l].ovf;
        dn[k][l].rem = ge ? PW'(t - {1'b0, dc[k].den}) : t[PW-1:0];
        dn[k][l].low = dl[k][l].low << 1;
        dn[k][l].q   = {dl[k][l].q[W-2:0], ge};
      end
    end
  end

  // saturation, sign and status
  always_comb begin
    logic [W-1:0] limit, qo;
    logic         sat, any_sat;
    res_data = '0;
    any_sat  = 1'b0;
    for (int l = 0; l < NLANE; l++) begin
      limit = dl[W][l].neg ? (W'(1) << (W-1)) : ((W'(1) << (W-1)) - 1'b1);
      sat   = dl[W][l].ovf || (dl[W][l].q > limit);
      qo    = sat ? limit : dl[W][l].q;
      any_sat = any_sat | sat;
      res_data[l*W +: W] = dl[W][l].neg ? (~qo + 1'b1) : qo;
    end
    if (dc[W].sing) begin
      res_data = '0;
      res_stat = STATUS_SINGULAR;
    end else if (any_sat) begin
      res_stat = STATUS_SAT;
    end else begin
      res_stat = STATUS_OK;
    end
  end

  logic incoming;
  assign incoming = en && dv[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
      vs <= 1'b0;
    end else if (!vo || m_tready) begin
      if (vs) begin
        vo <= 1'b1;
        vs <= 1'b0;
      end else begin
        vo <= incoming;
      end
    end else if (incoming) begin
      vs <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!vo || m_tready) begin
      if (vs) begin
        od <= sd;
        ou <= su;
      end else begin
        od <= res_data;
        ou <= res_stat;
      end
    end else if (incoming) begin
      sd <= res_data;
      su <= res_stat;
    end
  end

  assign m_tvalid = vo;
  assign m_tdata  = od;
  assign m_tuser  = ou;

endmodule

/* rtl/aff_checker.sv */
// Port-level checks for the affine inverse block, bound to the top level.
module aff_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [aff_pkg::TDATA_W-1:0] s_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [aff_pkg::TDATA_W-1:0] m_tdata,
  input logic [1:0]                  m_tuser
);
  import aff_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // singular model gives all-zero coefficients
  a_sing: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_SINGULAR |-> m_tdata == '0)
    else $error("singular result with nonzero coefficients");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_SINGULAR ||
                  m_tuser == STATUS_SAT))
    else $error("bad status code");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind affine_transform_inverter aff_checker u_aff_checker (.*);

/* test/affine_transform_inverter_tb.sv */
// Self-checking testbench for the affine model inverter: directed and random models.
module affine_transform_inverter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aff_pkg::*;

  typedef struct {
    logic [31:0] coef [6];
  } model_t;

  typedef struct {
    logic [31:0] inv [6];
    logic [1:0]  status;
  } inverse_t;

  // signed 128-bit quotient of num * 2^sh / den, truncated, saturated to 32 bits
  function automatic logic [31:0] fixed_div(input logic signed [127:0] num, input int sh,
                                            input logic signed [127:0] den, inout bit sat);
    logic signed [127:0] q;
    q = (num <<< sh) / den;
    if (q > 128'sd2147483647) begin
      sat = 1;
      return 32'h7fffffff;
    end
    if (q < -128'sd2147483648) begin
      sat = 1;
      return 32'h80000000;
    end
    return q[31:0];
  endfunction

  function automatic inverse_t invert_model(input model_t m);
    inverse_t r;
    logic signed [127:0] a, b, c, d, e, f, det;
    bit sat;
    a = $signed(m.coef[0]); b = $signed(m.coef[1]); c = $signed(m.coef[2]);
    d = $signed(m.coef[3]); e = $signed(m.coef[4]); f = $signed(m.coef[5]);
    det = b * f - c * e;
    sat = 0;
    if (det == 0) begin
      foreach (r.inv[k]) r.inv[k] = '0;
      r.status = STATUS_SINGULAR;
      return r;
    end
    r.inv[0] = fixed_div(c * d - a * f, FRAC_BITS, det, sat);
    r.inv[1] = fixed_div(f, 2 * FRAC_BITS, det, sat);
    r.inv[2] = fixed_div(-c, 2 * FRAC_BITS, det, sat);
    r.inv[3] = fixed_div(a * e - b * d, FRAC_BITS, det, sat);
    r.inv[4] = fixed_div(-e, 2 * FRAC_BITS, det, sat);
    r.inv[5] = fixed_div(b, 2 * FRAC_BITS, det, sat);
    r.status = sat ? STATUS_SAT : STATUS_OK;
    return r;
  endfunction

  int errors = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  class inverse_board;
    inverse_t pending[$];

    function void note_model(model_t m);
      pending.push_back(invert_model(m));
    endfunction

    task check_inverse(logic [TDATA_W-1:0] data, logic [1:0] status);
      inverse_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", data[31:0], '0);
        return;
      end
      w = pending.pop_front();
      for (int k = 0; k < 6; k++)
        if (data[32*k +: 32] !== w.inv[k]) report_mismatch($sformatf("inv[%0d]", k),
                                                            data[32*k +: 32], w.inv[k]);
      if (status !== w.status) report_mismatch("status", 32'(status), 32'(w.status));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0;
  logic s_tready, m_tvalid;
  logic [TDATA_W-1:0] s_tdata = '0, m_tdata;
  logic [1:0] m_tuser;

  affine_transform_inverter i_dut (.*);

  always #1 clk = ~clk;

  inverse_board board = new();
  bit sending_done = 0;
  bit hold_sink = 0;
  int idle_cycles = 0;

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h00010000 * $urandom_range(0, 4) - 32'h00020000;
      3: return $urandom_range(0, 3) - 1;
      4: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      default: return $urandom;
    endcase
  endfunction

  // s_tvalid stays high after a transfer unless the next item waits
  task automatic send_model(input model_t m);
    int idle;
    idle = $urandom_range(0, 3);
    if (idle > 0) begin
      s_tvalid <= 0;
      repeat (idle) @(posedge clk);
    end
    s_tvalid <= 1;
    for (int k = 0; k < 6; k++) s_tdata[32*k +: 32] <= m.coef[k];
    do @(posedge clk); while (!s_tready);
    board.note_model(m);
  endtask

  task automatic send_coefs(input logic [31:0] a, b, c, d, e, f);
    model_t m;
    m.coef = '{a, b, c, d, e, f};
    send_model(m);
  endtask

  // sender
  initial begin
    model_t m;
    logic [31:0] one;
    one = 32'h00010000;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_coefs(0, one, 0, 0, 0, one);
    send_coefs(one * 5, one * 2, 0, -one, 0, one * 4);
    send_coefs(0, 0, 0, 0, 0, 0);
    send_coefs(one, one, one, one, one, one);
    send_coefs(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
               32'h80000000);
    send_coefs(32'h80000000, 32'h80000000, 0, 32'h80000000, 0, 32'h80000000);
    send_coefs(32'h7fffffff, 32'h7fffffff, 0, 32'h80000000, 0, 32'h7fffffff);
    send_coefs(0, 1, 0, 0, 0, 1);
    send_coefs(32'h7fffffff, 1, 0, 32'h80000000, 0, 1);
    send_coefs(0, 0, one, 0, -one, 0);
    send_coefs(0, 0, 1, 0, 32'h80000000, 0);
    send_coefs(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1);
    send_coefs(32'haaaaaaaa, 32'h55555555, 32'h33333333, 32'hcccccccc, 32'h0f0f0f0f,
               32'hf0f0f0f0);
    s_tvalid <= 0;
    // drain completely before going on
    wait (board.pending.size() == 0);
    // long receiver hold-off while sender keeps offering
    hold_sink = 1;
    for (int n = 0; n < 1700; n++) begin
      for (int k = 0; k < 6; k++) m.coef[k] = rand_coef();
      if ($urandom_range(0, 9) == 0) m.coef[5] = 0;
      send_model(m);
    end
    s_tvalid <= 0;
    sending_done = 1;
  end

  // length of the receiver hold-off, in cycles
  initial begin
    wait (hold_sink);
    repeat (300) @(posedge clk);
    hold_sink = 0;
  end

  // receiver
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) board.check_inverse(m_tdata, m_tuser);
      if (hold_sink) m_tready <= 0;
      else if ($urandom_range(0, 3) == 0) m_tready <= 0;
      else m_tready <= 1;
    end
  end

  // watchdog and end of run
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 2000) begin
        $display("affine_transform_inverter verification failed");
        $finish;
      end
      if (sending_done && board.pending.size() == 0) begin
        repeat (60) @(posedge clk);
        if (errors == 0 && board.pending.size() == 0)
          $display("affine_transform_inverter verification clean");
        else
          $display("affine_transform_inverter verification failed");
        $finish;
      end
    end
  end
endmodule
